### rtl/core/i2cram_pkg.sv
// Shared types and constants of the I2C register-access master.
`default_nettype none

package i2cram_pkg;

  // Stream payload widths
  localparam int unsigned InDataW  = 24;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 16;

  // Address byte helpers
  localparam logic [7:0] MsbMask = 8'h80;
  localparam logic       ReadBit = 1'b1;
  localparam logic [2:0] LastBit = 3'd7;

  // Sequencer phases, one-hot
  typedef enum logic [14:0] {
    PH_IDLE      = 15'h0001,
    PH_START1    = 15'h0002,
    PH_SEND_DEVW = 15'h0004,
    PH_ACK_DEVW  = 15'h0008,
    PH_SEND_REG  = 15'h0010,
    PH_ACK_REG   = 15'h0020,
    PH_START2    = 15'h0040,
    PH_SEND_DEVR = 15'h0080,
    PH_ACK_DEVR  = 15'h0100,
    PH_RECV_REL  = 15'h0200,
    PH_RECV      = 15'h0400,
    PH_MACK      = 15'h0800,
    PH_SEND_DATA = 15'h1000,
    PH_ACK_DATA  = 15'h2000,
    PH_STOP      = 15'h4000
  } phase_e;

  // Full sequencer state
  typedef struct packed {
    phase_e     phase;
    logic [1:0] step;
    logic [2:0] bit_cnt;
    logic [7:0] shift;
    logic       opcode;
    logic [6:0] dev;
    logic [7:0] regad;
    logic [7:0] wdata;
    logic [7:0] rcv;
    logic       err;
    logic       scl;
    logic       sda;
  } state_t;

  // One decoded input beat
  typedef struct packed {
    logic       start_request;
    logic       opcode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_data;
    logic       sda_sampled;
  } tick_t;

endpackage : i2cram_pkg

`default_nettype wire

### rtl/core/i2cram_step.sv
// Next-state logic of the I2C sequencer: one pin update per tick.
`default_nettype none

module i2cram_step
  import i2cram_pkg::*;
(
  input  state_t st_i,
  input  tick_t  tick_i,
  output state_t st_o,
  output logic   busy_o,
  output logic   done_o
);

  // Enter a phase with step and bit count cleared
  function automatic state_t go_phase(input state_t s, input phase_e p);
    state_t r;
    r         = s;
    r.phase   = p;
    r.step    = 2'd0;
    r.bit_cnt = 3'd0;
    return r;
  endfunction

  always_comb begin
    state_t s;
    s      = st_i;
    busy_o = 1'b0;
    done_o = 1'b0;

    // Latch a command on an idle tick
    if (s.phase == PH_IDLE) begin
      if (tick_i.start_request) begin
        s.opcode = tick_i.opcode;
        s.dev    = tick_i.device_address;
        s.regad  = tick_i.register_address;
        s.wdata  = tick_i.write_data;
        s.err    = 1'b0;
        s        = go_phase(s, PH_START1);
      end
    end

    // Advance one pin update
    if (s.phase != PH_IDLE) begin
      busy_o = 1'b1;
      case (s.phase)
        PH_START1, PH_START2: begin
          case (s.step)
            2'd0: s.sda = 1'b1;
            2'd1: s.scl = 1'b1;
            2'd2: s.sda = 1'b0;
            default: s.scl = 1'b0;
          endcase
          if (s.step == 2'd3) begin
            if (s.phase == PH_START1) begin
              s       = go_phase(s, PH_SEND_DEVW);
              s.shift = {s.dev, 1'b0};
            end else begin
              s       = go_phase(s, PH_SEND_DEVR);
              s.shift = {s.dev, ReadBit};
            end
          end else begin
            s.step = s.step + 2'd1;
          end
        end
        PH_SEND_DEVW, PH_SEND_REG, PH_SEND_DEVR, PH_SEND_DATA: begin
          if (s.step == 2'd0) begin
            s.sda  = |(s.shift & MsbMask);
            s.step = 2'd1;
          end else if (s.step == 2'd1) begin
            s.scl  = 1'b1;
            s.step = 2'd2;
          end else begin
            s.scl   = 1'b0;
            s.shift = {s.shift[6:0], 1'b0};
            if (s.bit_cnt == LastBit) begin
              case (s.phase)
                PH_SEND_DEVW: s = go_phase(s, PH_ACK_DEVW);
                PH_SEND_REG:  s = go_phase(s, PH_ACK_REG);
                PH_SEND_DEVR: s = go_phase(s, PH_ACK_DEVR);
                default:      s = go_phase(s, PH_ACK_DATA);
              endcase
            end else begin
              s.bit_cnt = s.bit_cnt + 3'd1;
              s.step    = 2'd0;
            end
          end
        end
        PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DEVR, PH_ACK_DATA: begin
          if (s.step == 2'd0) begin
            s.sda  = 1'b1;
            s.step = 2'd1;
          end else if (s.step == 2'd1) begin
            s.scl  = 1'b1;
            s.err  = tick_i.sda_sampled;
            s.step = 2'd2;
          end else begin
            s.scl = 1'b0;
            // Route on the acknowledge; a NACK goes straight to stop
            if (s.err) begin
              s = go_phase(s, PH_STOP);
            end else begin
              case (s.phase)
                PH_ACK_DEVW: begin
                  s       = go_phase(s, PH_SEND_REG);
                  s.shift = s.regad;
                end
                PH_ACK_REG: begin
                  if (s.opcode) begin
                    s       = go_phase(s, PH_SEND_DATA);
                    s.shift = s.wdata;
                  end else begin
                    s = go_phase(s, PH_START2);
                  end
                end
                PH_ACK_DEVR: s = go_phase(s, PH_RECV_REL);
                default:     s = go_phase(s, PH_STOP);
              endcase
            end
          end
        end
        PH_RECV_REL: begin
          s.sda   = 1'b1;
          s       = go_phase(s, PH_RECV);
          s.shift = 8'h00;
        end
        PH_RECV: begin
          if (s.step == 2'd0) begin
            s.scl   = 1'b1;
            s.shift = {s.shift[6:0], tick_i.sda_sampled};
            s.step  = 2'd1;
          end else begin
            s.scl = 1'b0;
            if (s.bit_cnt == LastBit) begin
              s.rcv = s.shift;
              s     = go_phase(s, PH_MACK);
            end else begin
              s.bit_cnt = s.bit_cnt + 3'd1;
              s.step    = 2'd0;
            end
          end
        end
        PH_MACK: begin
          case (s.step)
            2'd0: s.sda = 1'b1;
            2'd1: s.scl = 1'b1;
            2'd2: s.scl = 1'b0;
            default: s.sda = 1'b1;
          endcase
          if (s.step == 2'd3) begin
            s = go_phase(s, PH_STOP);
          end else begin
            s.step = s.step + 2'd1;
          end
        end
        PH_STOP: begin
          if (s.step == 2'd0) begin
            s.sda  = 1'b0;
            s.step = 2'd1;
          end else if (s.step == 2'd1) begin
            s.scl  = 1'b1;
            s.step = 2'd2;
          end else begin
            s.sda  = 1'b1;
            s      = go_phase(s, PH_IDLE);
            done_o = 1'b1;
          end
        end
        default: begin
          s = go_phase(s, PH_IDLE);
        end
      endcase
    end

    st_o = s;
  end

endmodule : i2cram_step

`default_nettype wire

### rtl/core/i2cram_out_fifo.sv
// Two-entry result queue that decouples the input and output streams.
`default_nettype none

module i2cram_out_fifo
  import i2cram_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic [OutDataW-1:0] data_i,
  output logic                full_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  logic [OutDataW-1:0] mem_q [2];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                pop;

  assign pop             = m_axis_tvalid_o && m_axis_tready_i;
  assign full_o          = count_q[1];
  assign m_axis_tvalid_o = (count_q != 2'd0);
  assign m_axis_tdata_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule : i2cram_out_fifo

`default_nettype wire

### rtl/core/i2c_register_access_master.sv
// Top level of the I2C register-access master: state register and stream ports.
`default_nettype none

// Each input beat is one bus tick and yields exactly one result beat with the
// SCL/SDA levels to drive after that tick, busy, done, status and the last
// read byte. Throughput is one tick per clock cycle: the sequencer state is
// updated by a single combinational step on every accepted beat, and results
// are held in a two-entry queue, so input is taken whenever that queue is not
// full, independent of the output ready in the same cycle. A write
// transaction spans 88 ticks, a read 113 ticks (fewer when the target
// NACKs, which ends the transaction with a stop and status 1). Commands
// (start_request with opcode and addresses) are only honored on idle ticks.
module i2c_register_access_master
  import i2cram_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // [6:0] device_address, [14:7] register_address, [22:15] write_data,
  // [23] sda_sampled
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // [0] start_request, [1] opcode
  input  logic [InUserW-1:0]  s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] status,
  // [12:5] read_data, [15:13] zero
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  state_t              state_q, state_d;
  tick_t               tick;
  logic                accept;
  logic                busy, done;
  logic                fifo_full;
  logic [OutDataW-1:0] result;

  // Unpack the input beat
  assign tick.start_request    = s_axis_tuser_i[0];
  assign tick.opcode           = s_axis_tuser_i[1];
  assign tick.device_address   = s_axis_tdata_i[6:0];
  assign tick.register_address = s_axis_tdata_i[14:7];
  assign tick.write_data       = s_axis_tdata_i[22:15];
  assign tick.sda_sampled      = s_axis_tdata_i[23];

  assign s_axis_tready_o = !fifo_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  i2cram_step u_step (
    .st_i   (state_q),
    .tick_i (tick),
    .st_o   (state_d),
    .busy_o (busy),
    .done_o (done)
  );

  // Hold state between beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase   <= PH_IDLE;
      state_q.step    <= 2'd0;
      state_q.bit_cnt <= 3'd0;
      state_q.shift   <= 8'h00;
      state_q.opcode  <= 1'b0;
      state_q.dev     <= 7'h00;
      state_q.regad   <= 8'h00;
      state_q.wdata   <= 8'h00;
      state_q.rcv     <= 8'h00;
      state_q.err     <= 1'b0;
      state_q.scl     <= 1'b1;
      state_q.sda     <= 1'b1;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // Pack the result beat
  assign result = {3'b000, state_d.rcv, state_d.err, done, busy, state_d.sda, state_d.scl};

  i2cram_out_fifo u_out_fifo (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push_i          (accept),
    .data_i          (result),
    .full_o          (fifo_full),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

`ifndef SYNTHESIS
  // A finished transaction leaves the sequencer idle with both lines released
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && done |=> state_q.phase == PH_IDLE && state_q.scl && state_q.sda)
    else $error("sequencer not idle after done");

  // Idle ticks without a command keep the pins
  a_idle_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && state_q.phase == PH_IDLE && !tick.start_request
    |=> $stable(state_q.scl) && $stable(state_q.sda))
    else $error("pins moved on an idle tick");

  // Input stalls only while results wait
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o)
    else $error("input stalled with empty result queue");

  // Done is only reported on a busy tick
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |-> busy)
    else $error("done without busy");
`endif

endmodule : i2c_register_access_master

`default_nettype wire

### tb/i2cram_pins_checker.sv
// Stream monitor for the I2C register-access master: tick predictor and result check.
`timescale 1ns / 100ps

module i2cram_pins_checker
  import i2cram_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // [6:0] device_address, [14:7] register_address, [22:15] write_data,
  // [23] sda_sampled
  input  logic [InDataW-1:0]  s_tdata_i,
  // [0] start_request, [1] opcode
  input  logic [InUserW-1:0]  s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res, [4] status,
  // [12:5] read_data, [15:13] zero
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  fail_cnt_o,
  output int                  pins_due_o,
  output int                  txn_cnt_o,
  output int                  read_cnt_o,
  output int                  nack_cnt_o
);

  // One result beat, laid out as on the output bus
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] rdata;
    logic       status;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } pins_t;

  // Sequencer state of the predictor
  phase_e     seq_ph;
  logic [1:0] seq_step;
  logic [2:0] bit_idx;
  logic [7:0] shreg;
  logic       cmd_is_write;
  logic [6:0] cmd_dev;
  logic [7:0] cmd_reg;
  logic [7:0] cmd_data;
  logic [7:0] rx_byte;
  logic       nack_seen;
  logic       scl_q;
  logic       sda_q;

  pins_t pins_due[$];
  pins_t want;
  pins_t got;
  int    beat_idx;
  int    fail_total;
  int    txn_total;
  int    read_total;
  int    nack_total;

  initial begin
    fail_total = 0;
    txn_total  = 0;
    read_total = 0;
    nack_total = 0;
  end

  function automatic void clear_model();
    seq_ph       = PH_IDLE;
    seq_step     = '0;
    bit_idx      = '0;
    shreg        = '0;
    cmd_is_write = 1'b0;
    cmd_dev      = '0;
    cmd_reg      = '0;
    cmd_data     = '0;
    rx_byte      = '0;
    nack_seen    = 1'b0;
    scl_q        = 1'b1;
    sda_q        = 1'b1;
  endfunction

  function automatic void enter(input phase_e p);
    seq_ph   = p;
    seq_step = '0;
    bit_idx  = '0;
  endfunction

  function automatic void load_byte(input phase_e p, input logic [7:0] b);
    enter(p);
    shreg = b;
  endfunction

  // Ack phase that follows each byte-send phase
  function automatic phase_e ack_of(input phase_e p);
    case (p)
      PH_SEND_DEVW: return PH_ACK_DEVW;
      PH_SEND_REG:  return PH_ACK_REG;
      PH_SEND_DEVR: return PH_ACK_DEVR;
      default:      return PH_ACK_DATA;
    endcase
  endfunction

  // Pick the phase after an ack clock; a NACK goes straight to stop
  function automatic void after_ack();
    if (nack_seen) begin
      enter(PH_STOP);
    end else begin
      case (seq_ph)
        PH_ACK_DEVW: load_byte(PH_SEND_REG, cmd_reg);
        PH_ACK_REG: begin
          if (cmd_is_write) load_byte(PH_SEND_DATA, cmd_data);
          else enter(PH_START2);
        end
        PH_ACK_DEVR: enter(PH_RECV_REL);
        default:     enter(PH_STOP);
      endcase
    end
  endfunction

  // One pin update; returns 1 on the tick that ends the transaction
  function automatic logic pin_update(input logic sda_in);
    case (seq_ph)
      PH_START1, PH_START2: begin
        if (seq_step == 2'd3) begin
          scl_q = 1'b0;
          if (seq_ph == PH_START1) load_byte(PH_SEND_DEVW, {cmd_dev, 1'b0});
          else load_byte(PH_SEND_DEVR, {cmd_dev, ReadBit});
        end else begin
          case (seq_step)
            2'd0:    sda_q = 1'b1;
            2'd1:    scl_q = 1'b1;
            default: sda_q = 1'b0;
          endcase
          seq_step = seq_step + 2'd1;
        end
      end
      PH_SEND_DEVW, PH_SEND_REG, PH_SEND_DEVR, PH_SEND_DATA: begin
        if (seq_step == 2'd0) begin
          sda_q    = shreg[7];
          seq_step = 2'd1;
        end else if (seq_step == 2'd1) begin
          scl_q    = 1'b1;
          seq_step = 2'd2;
        end else begin
          scl_q = 1'b0;
          shreg = {shreg[6:0], 1'b0};
          if (bit_idx == LastBit) begin
            enter(ack_of(seq_ph));
          end else begin
            bit_idx  = bit_idx + 3'd1;
            seq_step = 2'd0;
          end
        end
      end
      PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DEVR, PH_ACK_DATA: begin
        if (seq_step == 2'd0) begin
          sda_q    = 1'b1;
          seq_step = 2'd1;
        end else if (seq_step == 2'd1) begin
          scl_q     = 1'b1;
          nack_seen = sda_in;
          seq_step  = 2'd2;
        end else begin
          scl_q = 1'b0;
          after_ack();
        end
      end
      PH_RECV_REL: begin
        sda_q = 1'b1;
        enter(PH_RECV);
        shreg = '0;
      end
      PH_RECV: begin
        if (seq_step == 2'd0) begin
          scl_q    = 1'b1;
          shreg    = {shreg[6:0], sda_in};
          seq_step = 2'd1;
        end else begin
          scl_q = 1'b0;
          if (bit_idx == LastBit) begin
            rx_byte = shreg;
            enter(PH_MACK);
          end else begin
            bit_idx  = bit_idx + 3'd1;
            seq_step = 2'd0;
          end
        end
      end
      PH_MACK: begin
        if (seq_step == 2'd3) begin
          sda_q = 1'b1;
          enter(PH_STOP);
        end else begin
          case (seq_step)
            2'd0:    sda_q = 1'b1;
            2'd1:    scl_q = 1'b1;
            default: scl_q = 1'b0;
          endcase
          seq_step = seq_step + 2'd1;
        end
      end
      PH_STOP: begin
        if (seq_step == 2'd0) begin
          sda_q    = 1'b0;
          seq_step = 2'd1;
        end else if (seq_step == 2'd1) begin
          scl_q    = 1'b1;
          seq_step = 2'd2;
        end else begin
          sda_q = 1'b1;
          enter(PH_IDLE);
          return 1'b1;
        end
      end
      default: enter(PH_IDLE);
    endcase
    return 1'b0;
  endfunction

  // Latch a command on an idle tick, then advance the bus by one step
  function automatic pins_t predict_pins(input logic go, input logic op,
                                         input logic [6:0] dev, input logic [7:0] rg,
                                         input logic [7:0] wd, input logic sda_in);
    pins_t r;
    r = '0;
    if (seq_ph == PH_IDLE && go) begin
      cmd_is_write = op;
      cmd_dev      = dev;
      cmd_reg      = rg;
      cmd_data     = wd;
      nack_seen    = 1'b0;
      enter(PH_START1);
    end
    if (seq_ph != PH_IDLE) begin
      r.busy = 1'b1;
      r.done = pin_update(sda_in);
    end
    r.scl    = scl_q;
    r.sda    = sda_q;
    r.status = nack_seen;
    r.rdata  = rx_byte;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] exp_v,
                                 input logic [7:0] got_v);
    fail_total++;
    if (fail_total <= 40)
      $display("[%0t] result beat %0d: %s expected %0h, got %0h",
               $time, beat_idx, what, exp_v, got_v);
  endtask

  // Predict on each input beat, compare on each output beat
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      clear_model();
      pins_due.delete();
      beat_idx = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        want = predict_pins(s_tuser_i[0], s_tuser_i[1], s_tdata_i[6:0], s_tdata_i[14:7],
                            s_tdata_i[22:15], s_tdata_i[23]);
        pins_due.push_back(want);
        if (want.done) begin
          txn_total++;
          if (!cmd_is_write) read_total++;
          if (want.status) nack_total++;
        end
      end
      if (m_tvalid_i && m_tready_i) begin
        if (pins_due.size() == 0) begin
          report_mismatch("beat with no result due", 8'h00, m_tdata_i[7:0]);
        end else begin
          want = pins_due.pop_front();
          got  = m_tdata_i;
          if (got.scl !== want.scl)
            report_mismatch("scl_level", 8'(want.scl), 8'(got.scl));
          if (got.sda !== want.sda)
            report_mismatch("sda_level", 8'(want.sda), 8'(got.sda));
          if (got.busy !== want.busy)
            report_mismatch("busy_res", 8'(want.busy), 8'(got.busy));
          if (got.done !== want.done)
            report_mismatch("done_res", 8'(want.done), 8'(got.done));
          if (got.status !== want.status)
            report_mismatch("status", 8'(want.status), 8'(got.status));
          if (got.rdata !== want.rdata)
            report_mismatch("read_data", want.rdata, got.rdata);
          if (got.pad !== want.pad)
            report_mismatch("pad bits", 8'(want.pad), 8'(got.pad));
        end
        beat_idx++;
      end
    end
    fail_cnt_o <= fail_total;
    pins_due_o <= pins_due.size();
    txn_cnt_o  <= txn_total;
    read_cnt_o <= read_total;
    nack_cnt_o <= nack_total;
  end

endmodule : i2cram_pins_checker

### tb/tb_i2c_register_access_master.sv
// Testbench top for the I2C register-access master: tick stimulus, target replies, verdict.
`timescale 1ns / 100ps

module tb_i2c_register_access_master;
  import i2cram_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Which ack the target refuses
  localparam int ACK_NONE = -1;
  localparam int ACK_DEV  = 0;
  localparam int ACK_REG  = 1;
  localparam int ACK_LAST = 2;

  // Target data bits on a read
  localparam int RD_RANDOM = 0;
  localparam int RD_ZEROS  = 1;
  localparam int RD_ONES   = 2;

  localparam int RandTicksPerMode = 380;
  localparam int StallCycles      = 300;

  logic                clk;
  logic                rst_n;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic [InUserW-1:0]  s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;

  int   fail_cnt;
  int   pins_due;
  int   txn_cnt;
  int   read_cnt;
  int   nack_cnt;
  int   ticks_sent;
  int   tx_idle_pct;
  int   rx_idle_pct;
  logic stall_req;

  i2c_register_access_master u_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  i2cram_pins_checker u_check (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_tvalid),
    .s_tready_i (s_tready),
    .s_tdata_i  (s_tdata),
    .s_tuser_i  (s_tuser),
    .m_tvalid_i (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_i  (m_tdata),
    .fail_cnt_o (fail_cnt),
    .pins_due_o (pins_due),
    .txn_cnt_o  (txn_cnt),
    .read_cnt_o (read_cnt),
    .nack_cnt_o (nack_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop in case the handshakes hang
  initial begin
    #200000;
    $display("CHECK FAILED");
    $finish;
  end

  // Result side: random holds, plus one long stall on request
  initial begin : sink
    int   hold_left;
    logic seen;
    hold_left = 0;
    seen      = 1'b0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != seen) begin
        seen      = stall_req;
        hold_left = StallCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Offer one tick beat after a random gap and hold it until taken
  task automatic send_tick(input logic go, input logic op, input logic [6:0] dev,
                           input logic [7:0] rg, input logic [7:0] wd, input logic sda);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {sda, wd, rg, dev};
    s_tuser  <= {op, go};
    do @(posedge clk); while (!s_tready);
    ticks_sent++;
  endtask

  task automatic idle_ticks(input int n);
    repeat (n)
      send_tick(1'b0, 1'($urandom_range(1)), 7'($urandom_range(127)),
                8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
  endtask

  // Drive one whole transaction; the target answers on the ack and data ticks,
  // and start requests with junk fields are sprinkled over the busy ticks
  task automatic run_txn(input logic op, input logic [6:0] dev, input logic [7:0] rg,
                         input logic [7:0] wd, input int refuse, input int rd_mode);
    int   ack_t [3];
    int   len;
    logic sda;
    ack_t[ACK_DEV]  = 29;
    ack_t[ACK_REG]  = 56;
    ack_t[ACK_LAST] = (op == OP_WRITE) ? 83 : 87;
    if (refuse != ACK_NONE) len = ack_t[refuse] + 5;
    else len = (op == OP_WRITE) ? 88 : 113;
    send_tick(1'b1, op, dev, rg, wd, 1'($urandom_range(1)));
    for (int t = 1; t < len; t++) begin
      sda = 1'($urandom_range(1));
      for (int k = 0; k < 3; k++)
        if (t == ack_t[k]) sda = (k == refuse);
      if (op == OP_READ && rd_mode != RD_RANDOM && t >= 90 && t <= 104 && t % 2 == 0)
        sda = (rd_mode == RD_ONES);
      send_tick($urandom_range(99) < 25, 1'($urandom_range(1)), 7'($urandom_range(127)),
                8'($urandom_range(255)), 8'($urandom_range(255)), sda);
    end
  endtask

  // Stimulus and verdict
  initial begin : stim
    int goal;
    int waited;
    int refuse;
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = '0;
    stall_req   = 1'b0;
    ticks_sent  = 0;
    tx_idle_pct = 6;
    rx_idle_pct = 56;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, both operations, every NACK point
    idle_ticks(3);
    run_txn(OP_WRITE, 7'h00, 8'h00, 8'h00, ACK_NONE, RD_RANDOM);
    run_txn(OP_WRITE, 7'h7F, 8'hFF, 8'hFF, ACK_NONE, RD_RANDOM);
    run_txn(OP_READ, 7'h7F, 8'hFF, 8'h00, ACK_NONE, RD_ONES);
    run_txn(OP_READ, 7'h00, 8'h00, 8'hFF, ACK_NONE, RD_ZEROS);
    idle_ticks(2);
    run_txn(OP_WRITE, 7'h55, 8'hAA, 8'h5A, ACK_DEV, RD_RANDOM);
    run_txn(OP_WRITE, 7'h2A, 8'h55, 8'hA5, ACK_REG, RD_RANDOM);
    run_txn(OP_WRITE, 7'h01, 8'h80, 8'h7E, ACK_LAST, RD_RANDOM);
    run_txn(OP_READ, 7'h40, 8'h01, 8'h00, ACK_LAST, RD_ONES);
    run_txn(OP_READ, 7'h3C, 8'hC3, 8'h00, ACK_REG, RD_RANDOM);
    run_txn(OP_READ, 7'h12, 8'h34, 8'h56, ACK_NONE, RD_RANDOM);

    // Random transactions in three idle regimes; the last one starts with a long stall
    for (int mode = 0; mode < 3; mode++) begin
      tx_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 56 : 0;
      rx_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 6 : 0;
      if (mode == 2) stall_req = ~stall_req;
      goal = ticks_sent + RandTicksPerMode;
      while (ticks_sent < goal) begin
        if ($urandom_range(99) < 5) idle_ticks($urandom_range(4, 12));
        else idle_ticks($urandom_range(0, 3));
        refuse = ($urandom_range(99) < 15) ? $urandom_range(ACK_LAST) : ACK_NONE;
        run_txn(1'($urandom_range(1)), 7'($urandom_range(127)), 8'($urandom_range(255)),
                8'($urandom_range(255)), refuse, $urandom_range(RD_ONES));
      end
    end
    idle_ticks(2);
    @(negedge clk);
    s_tvalid <= 1'b0;

    // Drain the remaining results, then settle
    waited = 0;
    while (pins_due != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);

    if (pins_due != 0) $display("%0d expected result beats never arrived", pins_due);
    $display("Ran %0d tick beats: %0d transactions finished, %0d of them reads, %0d NACKed.",
             ticks_sent, txn_cnt, read_cnt, nack_cnt);
    $display("Sender and receiver idles swapped between regimes, with one %0d-cycle hold-off.",
             StallCycles);
    if (fail_cnt == 0 && pins_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule : tb_i2c_register_access_master

### filelist.f
rtl/core/i2cram_pkg.sv
rtl/core/i2cram_step.sv
rtl/core/i2cram_out_fifo.sv
rtl/core/i2c_register_access_master.sv
tb/i2cram_pins_checker.sv
tb/tb_i2c_register_access_master.sv
